### rtl/core/bwcp_pkg.sv
// Shared constants, types and a helper function of the binary window code packer.
package bwcp_pkg;

    // Window geometry and history store depth.
    localparam int WIN_W    = 3;
    localparam int WIN_H    = 3;
    localparam int MAX_LINE = 2048;

    // Derived widths.
    localparam int CODE_W = WIN_W * WIN_H;
    localparam int LW_W   = 12;
    localparam int POS_W  = $clog2(MAX_LINE);
    localparam int CNT_W  = POS_W + 1;
    localparam int CMP_W  = (LW_W > CNT_W) ? LW_W : CNT_W;

    localparam logic [LW_W-1:0] LINE_WIDTH_RESET = LW_W'(640);

    // Bits of the code that hold every column except the newest one.
    localparam logic [CODE_W-1:0] LOW_MASK =
        CODE_W'((64'd1 << (CODE_W - WIN_H)) - 64'd1);

    // A pixel as it is handed from the issue side to the merge stage.
    typedef struct packed {
        logic             pixel;
        logic [POS_W-1:0] col;
        logic             zero;
        logic             bypass;
        logic [WIN_H-1:0] bypass_data;
    } iss_t;

    // A write back into the history store.
    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] addr;
        logic [WIN_H-1:0] data;
    } wr_t;

    // Shifts a column history down by one row and puts the new pixel on top.
    function automatic logic [WIN_H-1:0] shift_hist(input logic [WIN_H-1:0] h,
                                                    input logic pix);
        return (h >> 1) | (WIN_H'(pix) << (WIN_H - 1));
    endfunction

endpackage

### rtl/core/bwcp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module bwcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/bwcp_issue.sv
// Issue side: line width register, column position counter and history fill count.
module bwcp_issue import bwcp_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             line_width_wr,
    input  logic [LW_W-1:0]  line_width,
    input  logic             pixel_set,
    input  logic             accept,
    input  wr_t              wr,
    output iss_t             iss,
    output logic [POS_W-1:0] rd_addr
);

    logic [LW_W-1:0]  line_width_reg;
    logic [LW_W-1:0]  line_width_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;

    logic [CMP_W-1:0] lw_ext;
    logic [CMP_W-1:0] eff_width;
    logic [CMP_W-1:0] pos_inc;

    // A width of zero acts as one, and widths above the store depth saturate.
    assign lw_ext    = CMP_W'(line_width_reg);
    assign eff_width = (lw_ext == '0) ? CMP_W'(1) :
                       ((lw_ext > CMP_W'(MAX_LINE)) ? CMP_W'(MAX_LINE) : lw_ext);
    assign pos_inc   = CMP_W'(pos_reg) + CMP_W'(1);

    always_comb
    begin
        line_width_next = line_width_wr ? line_width : line_width_reg;

        pos_next = pos_reg;
        if (accept)
        begin
            pos_next = (pos_inc >= eff_width) ? '0 : POS_W'(pos_inc);
        end

        // Columns are always visited from zero upward, so the written entries
        // form a prefix of the store and one count tells which are valid.
        fill_next = fill_reg;
        if (wr.en && (CNT_W'(wr.addr) >= fill_reg))
        begin
            fill_next = CNT_W'(wr.addr) + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
            pos_reg        <= '0;
            fill_reg       <= '0;
        end
        else
        begin
            line_width_reg <= line_width_next;
            pos_reg        <= pos_next;
            fill_reg       <= fill_next;
        end
    end

    // A write back in the same cycle as the read of that entry is forwarded.
    assign iss.pixel       = pixel_set;
    assign iss.col         = pos_reg;
    assign iss.zero        = (CNT_W'(pos_reg) >= fill_reg);
    assign iss.bypass      = wr.en && (wr.addr == pos_reg);
    assign iss.bypass_data = wr.data;
    assign rd_addr         = pos_reg;

`ifndef NO_ASSERTIONS
    a_pos_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(pos_reg) < CNT_W'(MAX_LINE))
        else $error("column position beyond the history store");

    a_write_in_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (CNT_W'(wr.addr) <= fill_reg))
        else $error("history write skips past the filled prefix");
`endif

endmodule

### rtl/core/bwcp_merge.sv
// Merge stage: history update, write back, window shift and output register.
module bwcp_merge import bwcp_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pixel_valid,
    input  iss_t              iss,
    input  logic [WIN_H-1:0]  rd_data,
    input  logic              code_stall,
    output logic              accept,
    output logic              pixel_stall,
    output wr_t               wr,
    output logic              code_valid,
    output logic [CODE_W-1:0] window_code
);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    iss_t              s1_reg;
    iss_t              s1_next;
    logic [CODE_W-1:0] window_reg;
    logic [CODE_W-1:0] window_next;
    logic              code_valid_reg;
    logic              code_valid_next;
    logic [CODE_W-1:0] code_reg;
    logic [CODE_W-1:0] code_next;

    logic              advance;
    logic              move;
    logic [WIN_H-1:0]  hist_old;
    logic [WIN_H-1:0]  hist_new;
    logic [CODE_W-1:0] win_base;
    logic [CODE_W-1:0] win_new;

    assign advance     = !code_valid_reg || !code_stall;
    assign move        = s1_valid_reg && advance;
    assign pixel_stall = s1_valid_reg && !advance;
    assign accept      = pixel_valid && !pixel_stall;

    assign hist_old = s1_reg.bypass ? s1_reg.bypass_data :
                      (s1_reg.zero ? '0 : rd_data);
    assign hist_new = shift_hist(hist_old, s1_reg.pixel);

    // The window restarts empty at the first column of each line.
    assign win_base = (s1_reg.col == '0) ? '0 : window_reg;
    assign win_new  = (win_base >> WIN_H) |
                      (CODE_W'(hist_new) << (WIN_H * (WIN_W - 1)));

    assign wr.en   = move;
    assign wr.addr = s1_reg.col;
    assign wr.data = hist_new;

    always_comb
    begin
        s1_valid_next   = accept ? 1'b1 : (move ? 1'b0 : s1_valid_reg);
        s1_next         = accept ? iss : s1_reg;
        window_next     = move ? win_new : window_reg;
        code_valid_next = move || (code_valid_reg && code_stall);
        code_next       = move ? win_new : code_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            code_valid_reg <= 1'b0;
            window_reg     <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            code_valid_reg <= code_valid_next;
            window_reg     <= window_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg   <= s1_next;
        code_reg <= code_next;
    end

    assign code_valid  = code_valid_reg;
    assign window_code = code_reg;

`ifndef NO_ASSERTIONS
    a_line_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (move && (s1_reg.col == '0)) |=> ((window_reg & LOW_MASK) == '0))
        else $error("window not cleared at the start of a line");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("merge stage lost or changed a held pixel");
`endif

endmodule

### rtl/core/binary_window_code_packer.sv
// Top level of the binary window code packer: history RAM, issue side and merge stage.
//
//  channel      | handshake                  | payload
//  -------------+----------------------------+------------------------------
//  pixel in     | pixel_valid / pixel_stall  | pixel_set (1 bit)
//  code out     | code_valid / code_stall    | window_code (WIN_W*WIN_H bits)
//  line width   | line_width_wr              | line_width (12 bits)
//
// A pixel transfer can happen every clock cycle while pixel_stall is low. The one
// history RAM read-modify-write per pixel sets this rate, and a write back to the
// column being read is forwarded. A transfer loads the RAM read and the merge stage;
// the merge stage then loads the output register unless code_stall holds it.
// Reset sets the line width to 640 and clears the position and the RAM fill count.
// Entries beyond that count read as zero. An output stall holds both stages and the input.
module binary_window_code_packer import bwcp_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              line_width_wr,
    input  logic [LW_W-1:0]   line_width,
    input  logic              pixel_valid,
    output logic              pixel_stall,
    input  logic              pixel_set,
    output logic              code_valid,
    input  logic              code_stall,
    output logic [CODE_W-1:0] window_code
);

    logic             accept;
    iss_t             iss;
    wr_t              wr;
    logic [POS_W-1:0] rd_addr;
    logic [WIN_H-1:0] rd_data;

    // The column history store, one WIN_H-bit entry for every column.
    bwcp_ram #(
        .WIDTH(WIN_H),
        .DEPTH(MAX_LINE)
    ) u_hist_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // The issue side reads the column's history at the pixel transfer.
    bwcp_issue u_issue (
        .clk           (clk),
        .rst_n         (rst_n),
        .line_width_wr (line_width_wr),
        .line_width    (line_width),
        .pixel_set     (pixel_set),
        .accept        (accept),
        .wr            (wr),
        .iss           (iss),
        .rd_addr       (rd_addr)
    );

    // The merge stage updates the history, writes it back and builds the code.
    bwcp_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .iss         (iss),
        .rd_data     (rd_data),
        .code_stall  (code_stall),
        .accept      (accept),
        .pixel_stall (pixel_stall),
        .wr          (wr),
        .code_valid  (code_valid),
        .window_code (window_code)
    );

endmodule
